>>> rtl/core/cmt_pkg.sv
// Shared types and constants for the counted multiset table.
// Used by cmt_ctrl, cmt_dp, counted_multiset_table and the testbench; no dependencies.
package cmt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int AMT_W   = 16;
    localparam int TALLY_W = 16;
    localparam int USED_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the item, restart the address counter
        logic scan;     // read one entry, advance address
        logic wipe;     // zero the count at the address, advance address
        logic update;   // apply the command and issue the result
    } t_dp_ctl;

    // Datapath to controller
    typedef struct packed {
        logic addr_last;
    } t_dp_stat;

endpackage

>>> rtl/core/cmt_ctrl.sv
// Sequencer for the counted multiset table: reset sweep, scan or clear sweep, update.
// Depends on cmt_pkg.
module cmt_ctrl
    import cmt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [CMD_W-1:0]    i_command,
    input  t_dp_stat            i_stat,
    output t_dp_ctl             o_ctl,
    output logic                busy
);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_WIPE   = 6'b010000,
        S_UPDATE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_INIT: begin
                o_ctl.wipe = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state = (t_cmd'(i_command) == CMD_CLEAR) ? S_WIPE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last read word is evaluated here
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_WIPE: begin
                o_ctl.wipe = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_ctl.update = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> rtl/core/cmt_dp.sv
// Datapath of the counted multiset table: key and count memories, scan
// registers, update arithmetic and result registers. Depends on cmt_pkg.
module cmt_dp
    import cmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctl             i_ctl,
    output t_dp_stat            o_stat,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [AMT_W-1:0]    i_amount,
    output logic                o_valid,
    output logic [TALLY_W-1:0]  o_tally,
    output logic                o_present,
    output logic                o_table_full,
    output logic [USED_W-1:0]   o_entries_used
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [SW-1:0] COUNT_MAX = SW'({COUNT_BITS{1'b1}});

    logic [KEY_BITS-1:0]   mem_key [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] mem_cnt [TABLE_DEPTH];

    // item registers
    t_cmd                  r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [AMT_W-1:0]      r_amt;

    // scan registers
    logic [AW-1:0]         r_addr;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic                  r_found;
    logic [AW-1:0]         r_slot;
    logic [COUNT_BITS-1:0] r_slot_cnt;
    logic                  r_free_found;
    logic [AW-1:0]         r_free;
    logic [UW-1:0]         r_used;

    // write port
    logic                  cnt_we;
    logic                  key_we;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_cnt;

    // update results
    logic [SW-1:0]         sum;
    logic [SW-1:0]         cur_w;
    logic [SW-1:0]         amt_w;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  res_present;
    logic                  res_full;
    logic [UW-1:0]         n_used;
    logic                  amt_nz;

    assign o_stat.addr_last = (r_addr == LAST_ADDR);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= t_cmd'(i_command);
            r_key <= KEY_BITS'(i_key);
            r_amt <= i_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_ctl.load) begin
            r_addr <= '0;
        end else if (i_ctl.scan || i_ctl.wipe) begin
            r_addr <= o_stat.addr_last ? '0 : r_addr + AW'(1);
        end
    end

    // memories: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[wr_addr] <= wr_cnt;
        end
        if (key_we) begin
            mem_key[wr_addr] <= r_key;
        end
        r_rd_key <= mem_key[r_addr];
        r_rd_cnt <= mem_cnt[r_addr];
        r_rd_idx <= r_addr;
    end

    // search: first live match and lowest free entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.scan;
            if (i_ctl.load) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_rd_vld) begin
                if (!r_found && r_rd_cnt != '0 && r_rd_key == r_key) begin
                    r_found    <= 1'b1;
                    r_slot     <= r_rd_idx;
                    r_slot_cnt <= r_rd_cnt;
                end
                if (!r_free_found && r_rd_cnt == '0) begin
                    r_free_found <= 1'b1;
                    r_free       <= r_rd_idx;
                end
            end
        end
    end

    assign amt_nz = (r_amt != '0);
    assign cur_w  = SW'(r_slot_cnt);
    assign amt_w  = SW'(r_amt);
    assign sum    = cur_w + amt_w;

    always_comb begin
        cnt_we      = 1'b0;
        key_we      = 1'b0;
        wr_addr     = r_slot;
        wr_cnt      = '0;
        new_cnt     = r_slot_cnt;
        res_present = r_found;
        res_full    = 1'b0;
        n_used      = r_used;
        if (i_ctl.wipe) begin
            cnt_we  = 1'b1;
            wr_addr = r_addr;
        end else if (i_ctl.update) begin
            case (r_cmd)
                CMD_CLEAR: begin
                    new_cnt     = '0;
                    res_present = 1'b0;
                    n_used      = '0;
                end
                CMD_ADD: begin
                    if (amt_nz) begin
                        if (r_found) begin
                            new_cnt = (sum > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                        : sum[COUNT_BITS-1:0];
                            cnt_we  = 1'b1;
                        end else if (r_free_found) begin
                            new_cnt     = (amt_w > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                              : amt_w[COUNT_BITS-1:0];
                            wr_addr     = r_free;
                            cnt_we      = 1'b1;
                            key_we      = 1'b1;
                            res_present = 1'b1;
                            n_used      = r_used + UW'(1);
                        end else begin
                            new_cnt  = '0;
                            res_full = 1'b1;
                        end
                        wr_cnt = new_cnt;
                    end
                end
                CMD_REMOVE: begin
                    if (amt_nz && r_found) begin
                        cnt_we = 1'b1;
                        if (cur_w > amt_w) begin
                            new_cnt = COUNT_BITS'(cur_w - amt_w);
                        end else begin
                            new_cnt     = '0;
                            res_present = 1'b0;
                            if (r_used != '0) begin
                                n_used = r_used - UW'(1);
                            end
                        end
                        wr_cnt = new_cnt;
                    end
                end
                default: begin
                end
            endcase
            if (!res_present) begin
                new_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_used  <= '0;
        end else begin
            o_valid <= i_ctl.update;
            if (i_ctl.update) begin
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.update) begin
            o_tally        <= TALLY_W'(new_cnt);
            o_present      <= res_present;
            o_table_full   <= res_full;
            o_entries_used <= USED_W'(n_used);
        end
    end

endmodule

>>> rtl/core/counted_multiset_table.sv
// Counted multiset table: top level joining the sequencer and the datapath.
// Depends on cmt_pkg, cmt_ctrl and cmt_dp.
//
//  channel   handshake        signals
//  command   start / busy     i_command, i_key, i_amount
//  result    o_valid strobe   o_tally, o_present, o_table_full, o_entries_used
//
// The result strobe follows the accepting edge once the memory read address has
// visited every entry: a drain state evaluates the last read, the update state
// writes back and the result is registered. Clear has no read to drain; it sweeps
// the count memory to zero and then updates. After reset busy stays high while
// the count memory is swept to zero. The result shows for one cycle, the receiver
// cannot stall it, and a new item may start then.
module counted_multiset_table
    import cmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [AMT_W-1:0]    i_amount,
    output logic                o_valid,
    output logic [TALLY_W-1:0]  o_tally,
    output logic                o_present,
    output logic                o_table_full,
    output logic [USED_W-1:0]   o_entries_used
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    cmt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (stat),
        .o_ctl     (ctl),
        .busy      (busy)
    );

    cmt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .o_tally        (o_tally),
        .o_present      (o_present),
        .o_table_full   (o_table_full),
        .o_entries_used (o_entries_used)
    );

`ifndef ASSERT_OFF
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not make block busy");

    a_full_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_present && o_tally == '0))
        else $error("dropped add reports a present key");
`endif

endmodule

>>> verif/tb_counted_multiset_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for counted_multiset_table: directed corner items, then random
// add/remove/query/clear items checked against a behavioral copy of the table.
// Depends on cmt_pkg and the counted_multiset_table RTL.

typedef struct packed {
    logic [cmt_pkg::TALLY_W-1:0] tally;
    logic                        present;
    logic                        full;
    logic [cmt_pkg::USED_W-1:0]  used;
} t_tally_rec;

// Behavioral copy of the table plus the queue of results still owed by the block.
class t_tally_mirror;
    localparam int DEPTH = cmt_pkg::TABLE_DEPTH_DEF;
    localparam logic [cmt_pkg::TALLY_W-1:0] COUNT_MAX = '1;

    logic [cmt_pkg::KEY_W-1:0]   keys   [DEPTH];
    logic [cmt_pkg::TALLY_W-1:0] counts [DEPTH];
    int unsigned used;
    t_tally_rec  due_tallies [$];
    int unsigned errors;
    int unsigned n_cmd [4];
    int unsigned n_full, n_sat, n_freed, peak;

    function new();
        foreach (counts[i]) begin
            counts[i] = '0;
            keys[i]   = '0;
        end
        foreach (n_cmd[i]) n_cmd[i] = 0;
        used    = 0;
        errors  = 0;
        n_full  = 0;
        n_sat   = 0;
        n_freed = 0;
        peak    = 0;
    endfunction

    function int find_key(logic [cmt_pkg::KEY_W-1:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (counts[i] != 0 && keys[i] == k) return i;
        return -1;
    endfunction

    function int find_free();
        for (int i = 0; i < DEPTH; i++)
            if (counts[i] == 0) return i;
        return -1;
    endfunction

    function logic [cmt_pkg::TALLY_W-1:0] tally_of(logic [cmt_pkg::KEY_W-1:0] k);
        int slot;
        slot = find_key(k);
        return (slot >= 0) ? counts[slot] : '0;
    endfunction

    // Some key currently in the table, or a fresh random one when it is empty.
    function logic [cmt_pkg::KEY_W-1:0] held_key();
        int base;
        if (used == 0) return $urandom();
        base = $urandom_range(0, DEPTH - 1);
        for (int i = 0; i < DEPTH; i++)
            if (counts[(base + i) % DEPTH] != 0) return keys[(base + i) % DEPTH];
        return $urandom();
    endfunction

    function int unsigned pending();
        return due_tallies.size();
    endfunction

    function void note_item(cmt_pkg::t_cmd c, logic [cmt_pkg::KEY_W-1:0] k,
                            logic [cmt_pkg::AMT_W-1:0] a);
        int slot;
        logic [cmt_pkg::TALLY_W:0] sum;
        t_tally_rec r;
        r = '0;
        n_cmd[c]++;
        if (c == cmt_pkg::CMD_CLEAR) begin
            foreach (counts[i]) counts[i] = '0;
            used = 0;
        end else begin
            slot = find_key(k);
            if (c == cmt_pkg::CMD_ADD && a != 0) begin
                if (slot >= 0) begin
                    sum = {1'b0, counts[slot]} + a;
                    if (sum > COUNT_MAX) begin
                        counts[slot] = COUNT_MAX;
                        n_sat++;
                    end else begin
                        counts[slot] = sum[cmt_pkg::TALLY_W-1:0];
                    end
                end else begin
                    slot = find_free();
                    if (slot < 0) begin
                        r.full = 1'b1;
                        n_full++;
                    end else begin
                        keys[slot]   = k;
                        counts[slot] = a;
                        used++;
                    end
                end
            end else if (c == cmt_pkg::CMD_REMOVE && a != 0 && slot >= 0) begin
                if (counts[slot] > a) begin
                    counts[slot] = counts[slot] - a;
                end else begin
                    counts[slot] = '0;
                    used--;
                    n_freed++;
                    slot = -1;
                end
            end
            if (slot >= 0) begin
                r.tally   = counts[slot];
                r.present = 1'b1;
            end
        end
        r.used = cmt_pkg::USED_W'(used);
        if (used > peak) peak = used;
        due_tallies.push_back(r);
    endfunction

    function void check_tally(t_tally_rec got);
        t_tally_rec want;
        if (due_tallies.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected result tally=%h present=%b full=%b used=%0d",
                         $realtime, got.tally, got.present, got.full, got.used);
            return;
        end
        want = due_tallies.pop_front();
        if (got.tally !== want.tally || got.present !== want.present ||
            got.full !== want.full || got.used !== want.used) begin
            errors++;
            if (errors <= 10)
                $display("%0t: mismatch exp tally=%h present=%b full=%b used=%0d",
                         $realtime, want.tally, want.present, want.full, want.used,
                         " | got tally=%h present=%b full=%b used=%0d",
                         got.tally, got.present, got.full, got.used);
        end
    endfunction
endclass

module tb_counted_multiset_table;
    import cmt_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int POOL       = 72;
    localparam int RAND_ITEMS = 1850;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    t_cmd               cmd_d   = CMD_QUERY;
    logic [KEY_W-1:0]   key_d   = '0;
    logic [AMT_W-1:0]   amt_d   = '0;
    logic               busy;
    logic               o_valid;
    logic [TALLY_W-1:0] o_tally;
    logic               o_present;
    logic               o_table_full;
    logic [USED_W-1:0]  o_entries_used;

    t_tally_mirror      mirror = new();
    logic [KEY_W-1:0]   key_pool [POOL];
    int unsigned        n_sent = 0;

    counted_multiset_table uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (cmd_d),
        .i_key          (key_d),
        .i_amount       (amt_d),
        .o_valid        (o_valid),
        .o_tally        (o_tally),
        .o_present      (o_present),
        .o_table_full   (o_table_full),
        .o_entries_used (o_entries_used)
    );

    initial forever #1 i_clk = ~i_clk;

    initial begin
        #1_400_000;
        $display("counted_multiset_table test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            mirror.check_tally({o_tally, o_present, o_table_full, o_entries_used});
    end

    // Present one item and wait for the block to take it. With a random idle gap,
    // start drops until the block is free again and then for the length of the gap;
    // with no gap, start stays high so the next item is taken at once.
    task automatic send_item(t_cmd c, logic [KEY_W-1:0] k, logic [AMT_W-1:0] a);
        int unsigned gap;
        start <= 1'b1;
        cmd_d <= c;
        key_d <= k;
        amt_d <= a;
        do @(posedge i_clk); while (busy);
        mirror.note_item(c, k, a);
        n_sent++;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (mirror.pending() != 0);
    endtask

    function automatic logic [AMT_W-1:0] pick_amount();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return '0;
        if (sel < 14) return '1;
        if (sel < 22) return AMT_W'($urandom());
        if (sel < 28) return AMT_W'($urandom_range(16'h7F00, 16'hFFFE));
        return AMT_W'($urandom_range(1, 20));
    endfunction

    task automatic pool_burst(int unsigned len);
        int unsigned      sel;
        t_cmd             c;
        logic [KEY_W-1:0] k;
        logic [AMT_W-1:0] a;
        repeat (len) begin
            k   = key_pool[$urandom_range(0, POOL - 1)];
            sel = $urandom_range(0, 99);
            if (sel < 50) c = CMD_ADD;
            else if (sel < 75) c = CMD_REMOVE;
            else if (sel < 99) c = CMD_QUERY;
            else c = CMD_CLEAR;
            a = pick_amount();
            // exact removal frees the entry on the boundary
            if (c == CMD_REMOVE && $urandom_range(0, 3) == 0) a = mirror.tally_of(k);
            send_item(c, k, a);
        end
    endtask

    // Fill the table, push a few adds past full, then remove or query held keys and add new ones.
    task automatic fill_burst();
        logic [KEY_W-1:0] k;
        while (mirror.used < DEPTH)
            send_item(CMD_ADD, $urandom(), AMT_W'($urandom_range(1, 16'hFFFF)));
        repeat ($urandom_range(1, 3)) send_item(CMD_ADD, $urandom(), pick_amount());
        repeat ($urandom_range(2, 6)) begin
            k = mirror.held_key();
            case ($urandom_range(0, 2))
                0: send_item(CMD_REMOVE, k, mirror.tally_of(k));
                1: send_item(CMD_REMOVE, k, pick_amount());
                default: send_item(CMD_QUERY, k, AMT_W'($urandom()));
            endcase
            send_item(CMD_ADD, $urandom(), pick_amount());
        end
    endtask

    initial begin
        int unsigned sel;
        int unsigned last_pause;

        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_item(CMD_QUERY,  32'h0000_0000, 16'h0000);
        send_item(CMD_ADD,    32'h0000_0000, 16'h0000);   // zero amount, absent key
        send_item(CMD_ADD,    32'h0000_0000, 16'h0001);
        send_item(CMD_ADD,    32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_ADD,    32'hFFFF_FFFF, 16'h0001);   // saturates
        send_item(CMD_QUERY,  32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000);   // zero amount, present key
        send_item(CMD_REMOVE, 32'hA5A5_A5A5, 16'h0007);   // absent key
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0001);
        send_item(CMD_REMOVE, 32'h0000_0000, 16'h0001);   // exact count frees entry
        send_item(CMD_QUERY,  32'h0000_0000, 16'h5555);
        send_item(CMD_ADD,    32'h5A5A_5A5A, 16'h0003);
        send_item(CMD_REMOVE, 32'h5A5A_5A5A, 16'hFFFF);   // more than the count
        send_item(CMD_ADD,    32'h0000_0001, 16'hFFFF);   // new key at max
        send_item(CMD_ADD,    32'h8000_0000, 16'h8000);
        send_item(CMD_ADD,    32'h8000_0000, 16'h8000);   // sum one past max
        send_item(CMD_REMOVE, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_QUERY,  32'h0000_0001, 16'hAAAA);
        send_item(CMD_CLEAR,  32'h0000_0001, 16'hFFFF);
        send_item(CMD_QUERY,  32'h0000_0001, 16'h0000);
        send_item(CMD_ADD,    32'h0000_0001, 16'h0000);
        send_item(CMD_REMOVE, 32'h0000_0001, 16'h0000);
        drain();

        fill_burst();
        last_pause = n_sent;
        while (n_sent < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                pool_burst($urandom_range(5, 30));
            end else if (sel < 80) begin
                fill_burst();
            end else if (sel < 84) begin
                send_item(CMD_CLEAR, $urandom(), AMT_W'($urandom()));
            end else if (sel < 97) begin
                send_item(t_cmd'($urandom_range(0, 3)), $urandom(), AMT_W'($urandom()));
            end else begin
                foreach (key_pool[i]) key_pool[i] = $urandom();
            end
            if (n_sent - last_pause >= 300) begin
                drain();
                last_pause = n_sent;
            end
        end

        drain();
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Ran %0d items: add %0d, remove %0d, query %0d, clear %0d; %0d mismatches.",
                 n_sent, mirror.n_cmd[CMD_ADD], mirror.n_cmd[CMD_REMOVE],
                 mirror.n_cmd[CMD_QUERY], mirror.n_cmd[CMD_CLEAR], mirror.errors);
        $display("Dropped on full table %0d, saturated adds %0d, entries freed %0d, peak use %0d.",
                 mirror.n_full, mirror.n_sat, mirror.n_freed, mirror.peak);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("counted_multiset_table test passed");
        end else begin
            $display("counted_multiset_table test failed");
        end
        $finish;
    end
endmodule
